// ===== rtl/ebts_pkg.sv =====
// ----------------------------------------------------------------------------
// ebts_pkg
// Shared constants and types for the encoder and button tick sampler.
// ----------------------------------------------------------------------------
package ebts_pkg;

    localparam int unsigned NUM_ENCODERS = 2;
    localparam int unsigned NUM_BUTTONS  = 3;
    localparam int unsigned ENC_SLOTS    = 2;
    localparam int unsigned BTN_SLOTS    = 3;

    localparam int unsigned DEB_W = 10;
    localparam int unsigned CNT_W = 11;
    localparam int unsigned PER_W = 16;
    localparam int unsigned IDX_W = 2;
    localparam int unsigned CFG_W = 16;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(10);
    localparam logic [PER_W-1:0] DISPLAY_RESET  = PER_W'(10);
    localparam logic [PER_W-1:0] MOTION_RESET   = PER_W'(20);

    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_DISPLAY  = 2'd1,
        REG_MOTION   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic right;
        logic left;
    } t_enc_flags;

    typedef struct packed {
        logic pressed;
        logic released;
    } t_btn_flags;

endpackage

// ===== rtl/ebts_enc_lane.sv =====
// ----------------------------------------------------------------------------
// ebts_enc_lane
// One quadrature encoder lane: keeps the previous A/B pair and flags steps.
// ----------------------------------------------------------------------------
module ebts_enc_lane
    import ebts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_primed,
    input  logic [1:0] i_pins,
    output t_enc_flags o_flags
);

    logic [1:0] r_prev;
    logic       pa;
    logic       pb;
    t_enc_flags flags;

    assign pa = r_prev[1];
    assign pb = r_prev[0];

    always_comb begin
        flags = '0;
        if (i_primed && (i_pins != r_prev)) begin
            case (i_pins)
                2'b00: begin
                    flags.right = pb;
                    flags.left  = pa;
                end
                2'b01: begin
                    flags.right = pa;
                    flags.left  = !pb;
                end
                2'b10: begin
                    flags.right = !pa;
                    flags.left  = pb;
                end
                default: begin
                    flags.right = !pb;
                    flags.left  = !pa;
                end
            endcase
        end
    end

    assign o_flags = flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_accept) begin
            r_prev <= i_pins;
        end
    end

endmodule

// ===== rtl/ebts_btn_lane.sv =====
// ----------------------------------------------------------------------------
// ebts_btn_lane
// One button lane: debounce counter with press and release detection.
// ----------------------------------------------------------------------------
module ebts_btn_lane
    import ebts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_pin,
    input  logic [DEB_W-1:0] i_threshold,
    output t_btn_flags       o_flags
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] thr;
    logic [CNT_W-1:0] thr_plus;
    logic             down;
    t_btn_flags       flags;

    assign down     = !i_pin;
    assign thr      = CNT_W'(i_threshold);
    assign thr_plus = thr + CNT_W'(1);

    always_comb begin
        n_count = r_count;
        flags   = '0;
        if (down) begin
            if (r_count < thr) begin
                n_count = r_count + CNT_W'(1);
            end else if (r_count == thr) begin
                n_count       = r_count + CNT_W'(1);
                flags.pressed = 1'b1;
            end
        end else begin
            flags.released = (r_count == thr_plus);
            n_count        = '0;
        end
    end

    assign o_flags = flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/ebts_period.sv =====
// ----------------------------------------------------------------------------
// ebts_period
// Period counter: pulses once every period plus one ticks.
// ----------------------------------------------------------------------------
module ebts_period
    import ebts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [PER_W-1:0] i_period,
    output logic             o_pulse
);

    logic [PER_W-1:0] r_count;
    logic [PER_W-1:0] n_count;

    always_comb begin
        if (r_count < i_period) begin
            n_count = r_count + PER_W'(1);
            o_pulse = 1'b0;
        end else begin
            n_count = '0;
            o_pulse = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/encoder_button_tick_sampler.sv =====
// result word: registered from an accepted input word, valid in the cycle after
// throughput: one word per cycle while the output is not stalled, set by the single result register
// every lane updates its state in the cycle the word is accepted
// synchronous active-low reset clears lane state, counters and result valid
// registers return to debounce 10, display period 10, motion period 20
// ----------------------------------------------------------------------------
// encoder_button_tick_sampler
// Encoder and button lanes run side by side; flags are merged into one word.
// ----------------------------------------------------------------------------
module encoder_button_tick_sampler
    import ebts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_enc0_pin_a,
    input  logic             i_enc0_pin_b,
    input  logic             i_enc1_pin_a,
    input  logic             i_enc1_pin_b,
    input  logic [2:0]       i_button_pins,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_rotated_right,
    output logic [1:0]       o_rotated_left,
    output logic [2:0]       o_button_pressed_events,
    output logic [2:0]       o_button_released_events,
    output logic             o_display_pulse,
    output logic             o_motion_pulse
);

    logic [DEB_W-1:0] r_debounce;
    logic [PER_W-1:0] r_disp_period;
    logic [PER_W-1:0] r_motion_period;
    logic             r_primed;
    logic             accept;
    logic [1:0]       enc_pins [ENC_SLOTS];
    t_enc_flags       enc_flags [ENC_SLOTS];
    t_btn_flags       btn_flags [BTN_SLOTS];
    logic [1:0]       n_right;
    logic [1:0]       n_left;
    logic [2:0]       n_pressed;
    logic [2:0]       n_released;
    logic             disp_pulse;
    logic             motion_pulse;

    logic             r_out_valid;
    logic [1:0]       r_right;
    logic [1:0]       r_left;
    logic [2:0]       r_pressed;
    logic [2:0]       r_released;
    logic             r_disp;
    logic             r_motion;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce      <= DEBOUNCE_RESET;
            r_disp_period   <= DISPLAY_RESET;
            r_motion_period <= MOTION_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEBOUNCE: r_debounce      <= i_cfg_data[DEB_W-1:0];
                REG_DISPLAY:  r_disp_period   <= i_cfg_data;
                REG_MOTION:   r_motion_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (accept) begin
            r_primed <= 1'b1;
        end
    end

    assign enc_pins[0] = {i_enc0_pin_a, i_enc0_pin_b};
    assign enc_pins[1] = {i_enc1_pin_a, i_enc1_pin_b};

    // encoder lanes
    for (genvar g = 0; g < ENC_SLOTS; g++) begin : g_enc
        if (g < NUM_ENCODERS) begin : g_used
            ebts_enc_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_accept (accept),
                .i_primed (r_primed),
                .i_pins   (enc_pins[g]),
                .o_flags  (enc_flags[g])
            );
        end else begin : g_unused
            assign enc_flags[g] = '0;
        end
    end

    // button lanes
    for (genvar g = 0; g < BTN_SLOTS; g++) begin : g_btn
        if (g < NUM_BUTTONS) begin : g_used
            ebts_btn_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_accept    (accept),
                .i_pin       (i_button_pins[g]),
                .i_threshold (r_debounce),
                .o_flags     (btn_flags[g])
            );
        end else begin : g_unused
            assign btn_flags[g] = '0;
        end
    end

    ebts_period u_disp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_period (r_disp_period),
        .o_pulse  (disp_pulse)
    );

    ebts_period u_motion (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_period (r_motion_period),
        .o_pulse  (motion_pulse)
    );

    // merge lane flags into one word
    always_comb begin
        for (int k = 0; k < ENC_SLOTS; k++) begin
            n_right[k] = enc_flags[k].right;
            n_left[k]  = enc_flags[k].left;
        end
        for (int k = 0; k < BTN_SLOTS; k++) begin
            n_pressed[k]  = btn_flags[k].pressed;
            n_released[k] = btn_flags[k].released;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_right    <= n_right;
            r_left     <= n_left;
            r_pressed  <= n_pressed;
            r_released <= n_released;
            r_disp     <= disp_pulse;
            r_motion   <= motion_pulse;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_rotated_right          = r_right;
    assign o_rotated_left           = r_left;
    assign o_button_pressed_events  = r_pressed;
    assign o_button_released_events = r_released;
    assign o_display_pulse          = r_disp;
    assign o_motion_pulse           = r_motion;

endmodule

// ===== tb/tb_encoder_button_tick_sampler.sv =====
// ----------------------------------------------------------------------------
// tb_encoder_button_tick_sampler
// Self-checking bench for the encoder and button tick sampler. Pin sample
// words go in over a valid/ready channel, and a local model of the quadrature
// rule, the button debounce and the two period counters predicts every
// result word. Directed tests cover the first tick after reset, every encoder
// transition, debounce and period edge cases and the spare register index.
// Random phases then run gray-code walks with some random jumps and
// press/bounce sequences under several register settings, with random gaps
// on both sides; one phase runs under a long output stall.
// ----------------------------------------------------------------------------
module tb_encoder_button_tick_sampler;
    import ebts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic       enc0_a;
        logic       enc0_b;
        logic       enc1_a;
        logic       enc1_b;
        logic [2:0] buttons;
    } t_tick;

    typedef struct packed {
        logic [1:0] right;
        logic [1:0] left;
        logic [2:0] pressed;
        logic [2:0] released;
        logic       display;
        logic       motion;
    } t_tick_result;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic             i_enc0_pin_a = 1'b0;
    logic             i_enc0_pin_b = 1'b0;
    logic             i_enc1_pin_a = 1'b0;
    logic             i_enc1_pin_b = 1'b0;
    logic [2:0]       i_button_pins = 3'b111;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [1:0]       o_rotated_right;
    logic [1:0]       o_rotated_left;
    logic [2:0]       o_button_pressed_events;
    logic [2:0]       o_button_released_events;
    logic             o_display_pulse;
    logic             o_motion_pulse;

    encoder_button_tick_sampler dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cfg_valid              (i_cfg_valid),
        .o_cfg_ready              (o_cfg_ready),
        .i_cfg_index              (i_cfg_index),
        .i_cfg_data               (i_cfg_data),
        .i_in_valid               (i_in_valid),
        .o_in_ready               (o_in_ready),
        .i_enc0_pin_a             (i_enc0_pin_a),
        .i_enc0_pin_b             (i_enc0_pin_b),
        .i_enc1_pin_a             (i_enc1_pin_a),
        .i_enc1_pin_b             (i_enc1_pin_b),
        .i_button_pins            (i_button_pins),
        .o_out_valid              (o_out_valid),
        .i_out_ready              (i_out_ready),
        .o_rotated_right          (o_rotated_right),
        .o_rotated_left           (o_rotated_left),
        .o_button_pressed_events  (o_button_pressed_events),
        .o_button_released_events (o_button_released_events),
        .o_display_pulse          (o_display_pulse),
        .o_motion_pulse           (o_motion_pulse)
    );

    // model state and register copies
    logic [DEB_W-1:0] deb_thr;
    logic [PER_W-1:0] disp_per;
    logic [PER_W-1:0] mot_per;
    logic [1:0]       enc_last [ENC_SLOTS];
    logic             enc_armed;
    logic [CNT_W-1:0] btn_count [BTN_SLOTS];
    logic [PER_W-1:0] disp_cnt;
    logic [PER_W-1:0] mot_cnt;

    t_tick_result expected_ticks [$];
    int unsigned  mismatches;
    int unsigned  cycle_count;

    // stimulus generator state
    logic [1:0] gen_pins [ENC_SLOTS];
    logic       gen_level [BTN_SLOTS];
    int         gen_run [BTN_SLOTS];
    bit         tx_idle;
    bit         rx_idle;

    // receiver stall control
    int sink_stall;
    int hold_left;
    int hold_len;
    bit hold_tgl;
    bit hold_seen;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** encoder_button_tick_sampler: FAILED **");
            $finish;
        end
    end

    function automatic void reset_model();
        int k;
        deb_thr   = DEBOUNCE_RESET;
        disp_per  = DISPLAY_RESET;
        mot_per   = MOTION_RESET;
        enc_armed = 1'b0;
        disp_cnt  = '0;
        mot_cnt   = '0;
        for (k = 0; k < ENC_SLOTS; k++) begin
            enc_last[k] = 2'b00;
            gen_pins[k] = 2'b00;
        end
        for (k = 0; k < BTN_SLOTS; k++) begin
            btn_count[k] = '0;
            gen_level[k] = 1'b1;
            gen_run[k]   = 0;
        end
    endfunction

    function automatic logic period_elapsed(ref logic [PER_W-1:0] cnt,
                                            input logic [PER_W-1:0] per);
        if (cnt < per) begin
            cnt = cnt + PER_W'(1);
            return 1'b0;
        end
        cnt = '0;
        return 1'b1;
    endfunction

    function automatic t_tick_result predict_tick(t_tick tk);
        t_tick_result r;
        logic [1:0]       ab;
        logic             pa;
        logic             pb;
        logic             down;
        logic [CNT_W-1:0] c;
        logic [CNT_W-1:0] thr;
        int               e;
        int               b;
        r   = '0;
        thr = {1'b0, deb_thr};
        for (e = 0; e < NUM_ENCODERS; e++) begin
            ab = (e == 0) ? {tk.enc0_a, tk.enc0_b} : {tk.enc1_a, tk.enc1_b};
            pa = enc_last[e][1];
            pb = enc_last[e][0];
            if (enc_armed && ab != enc_last[e]) begin
                case (ab)
                    2'b00: begin r.right[e] = pb;  r.left[e] = pa;  end
                    2'b01: begin r.right[e] = pa;  r.left[e] = !pb; end
                    2'b10: begin r.right[e] = !pa; r.left[e] = pb;  end
                    default: begin r.right[e] = !pb; r.left[e] = !pa; end
                endcase
            end
            enc_last[e] = ab;
        end
        enc_armed = 1'b1;
        for (b = 0; b < NUM_BUTTONS; b++) begin
            down = !tk.buttons[b];
            c    = btn_count[b];
            if (down && c < thr) begin
                btn_count[b] = c + CNT_W'(1);
            end else if (down && c == thr) begin
                btn_count[b] = c + CNT_W'(1);
                r.pressed[b] = 1'b1;
            end else if (!down) begin
                if (c == thr + CNT_W'(1))
                    r.released[b] = 1'b1;
                btn_count[b] = '0;
            end
        end
        r.display = period_elapsed(disp_cnt, disp_per);
        r.motion  = period_elapsed(mot_cnt, mot_per);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [2:0] got, logic [2:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_tick_result();
        t_tick_result want;
        if (expected_ticks.size() == 0) begin
            report_mismatch("result word with nothing outstanding");
            return;
        end
        want = expected_ticks.pop_front();
        check_field("rotated_right", 3'(o_rotated_right), 3'(want.right));
        check_field("rotated_left", 3'(o_rotated_left), 3'(want.left));
        check_field("button_pressed_events", o_button_pressed_events, want.pressed);
        check_field("button_released_events", o_button_released_events, want.released);
        check_field("display_pulse", 3'(o_display_pulse), 3'(want.display));
        check_field("motion_pulse", 3'(o_motion_pulse), 3'(want.motion));
    endtask

    // result side: checks each word and draws its own stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_stall = 0;
            hold_left  = 0;
            hold_seen  = hold_tgl;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_tick_result();
                sink_stall = rx_idle ? $urandom_range(0, 9) : 0;
            end else if (sink_stall > 0) begin
                sink_stall--;
            end
            if (hold_tgl != hold_seen) begin
                hold_seen = hold_tgl;
                hold_left = hold_len;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            i_out_ready <= (sink_stall == 0) && (hold_left == 0);
        end
    end

    task automatic send_tick(t_tick tk);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_enc0_pin_a  <= tk.enc0_a;
        i_enc0_pin_b  <= tk.enc0_b;
        i_enc1_pin_a  <= tk.enc1_a;
        i_enc1_pin_b  <= tk.enc1_b;
        i_button_pins <= tk.buttons;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_ticks.push_back(predict_tick(tk));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_DEBOUNCE: deb_thr  = data[DEB_W-1:0];
            REG_DISPLAY:  disp_per = data[PER_W-1:0];
            REG_MOTION:   mot_per  = data[PER_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_tick make_tick(logic [1:0] p0, logic [1:0] p1, logic [2:0] btn);
        t_tick tk;
        tk.enc0_a  = p0[1];
        tk.enc0_b  = p0[0];
        tk.enc1_a  = p1[1];
        tk.enc1_b  = p1[0];
        tk.buttons = btn;
        return tk;
    endfunction

    // single gray steps and holds about equally often, now and then a random jump
    function automatic logic [1:0] step_pins(logic [1:0] cur);
        logic [1:0] pos;
        int         roll;
        roll = $urandom_range(0, 19);
        pos  = {cur[1], cur[1] ^ cur[0]};
        if (roll < 9)
            return cur;
        if (roll < 14)
            pos = pos + 2'd1;
        else if (roll < 19)
            pos = pos - 2'd1;
        else
            return 2'($urandom);
        return {pos[1], pos[1] ^ pos[0]};
    endfunction

    // presses either long enough to qualify or short bounces
    function automatic t_tick random_tick();
        logic [2:0] btn;
        int         b;
        btn = '0;
        gen_pins[0] = step_pins(gen_pins[0]);
        gen_pins[1] = step_pins(gen_pins[1]);
        for (b = 0; b < BTN_SLOTS; b++) begin
            if (gen_run[b] == 0) begin
                gen_level[b] = !gen_level[b];
                if (!gen_level[b] && $urandom_range(0, 1))
                    gen_run[b] = $urandom_range(int'(deb_thr) + 1, int'(deb_thr) + 3);
                else
                    gen_run[b] = $urandom_range(1, 6);
            end
            gen_run[b]--;
            btn[b] = gen_level[b];
        end
        return make_tick(gen_pins[0], gen_pins[1], btn);
    endfunction

    task automatic test_encoder_walk();
        logic [1:0] walk [18] = '{2'd3, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3,
                                  2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
        int k;
        // first word after reset only records the pins
        for (k = 0; k < 18; k++)
            send_tick(make_tick(walk[k], walk[k] ^ 2'b01, 3'(k)));
        drain_results();
    endtask

    task automatic test_debounce_edges();
        int k;
        write_reg(REG_DEBOUNCE, 16'h0000);
        send_tick(make_tick(2'b00, 2'b00, 3'b000));
        send_tick(make_tick(2'b00, 2'b00, 3'b111));
        // upper data bits fall outside the register
        write_reg(REG_DEBOUNCE, 16'hFC02);
        for (k = 0; k < 4; k++)
            send_tick(make_tick(2'b00, 2'b00, 3'b000));
        // lowered threshold below a running count
        write_reg(REG_DEBOUNCE, 16'h0001);
        send_tick(make_tick(2'b00, 2'b00, 3'b010));
        send_tick(make_tick(2'b00, 2'b00, 3'b111));
        drain_results();
    endtask

    task automatic test_spare_index();
        write_reg(REG_SPARE, 16'hFFFF);
        send_tick(make_tick(2'b00, 2'b00, 3'b111));
        send_tick(make_tick(2'b00, 2'b00, 3'b110));
        send_tick(make_tick(2'b00, 2'b00, 3'b110));
        drain_results();
    endtask

    task automatic test_period_lowered();
        int k;
        write_reg(REG_DISPLAY, 16'hFFFF);
        write_reg(REG_MOTION, 16'hFFFF);
        for (k = 0; k < 5; k++)
            send_tick(make_tick(2'b00, 2'b00, 3'b111));
        write_reg(REG_DISPLAY, 16'd2);
        write_reg(REG_MOTION, 16'd0);
        for (k = 0; k < 4; k++)
            send_tick(make_tick(2'b00, 2'b00, 3'b111));
        drain_results();
    endtask

    task automatic test_output_stall();
        int k;
        tx_idle = 1'b0;
        rx_idle <= 1'b0;
        hold_len <= 40;
        hold_tgl <= !hold_tgl;
        for (k = 0; k < 30; k++)
            send_tick(random_tick());
        drain_results();
    endtask

    task automatic run_phase(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] disp,
                             logic [CFG_W-1:0] mot, int n_ticks, bit tx, bit rx);
        int k;
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_DISPLAY, disp);
        write_reg(REG_MOTION, mot);
        tx_idle = tx;
        rx_idle <= rx;
        for (k = 0; k < n_ticks; k++)
            send_tick(random_tick());
    endtask

    task automatic test_random_settings();
        run_phase(16'd10, 16'd10, 16'd20, 200, 1'b1, 1'b1);
        run_phase(16'd0, 16'd0, 16'hFFFF, 150, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'd1, 1100, 1'b0, 1'b1);
        run_phase(16'd3, 16'd5, 16'd7, 120, 1'b1, 1'b0);
        run_phase(16'd1, 16'd1, 16'd0, 100, 1'b1, 1'b1);
        drain_results();
    endtask

    task automatic finish_run();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_ticks.size() == 0)
            $display("** encoder_button_tick_sampler: PASSED **");
        else
            $display("** encoder_button_tick_sampler: FAILED **");
        $finish;
    endtask

    initial begin
        mismatches  = 0;
        cycle_count = 0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        hold_len    = 0;
        hold_tgl    = 1'b0;
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_encoder_walk();
        test_debounce_edges();
        test_spare_index();
        test_period_lowered();
        test_output_stall();
        test_random_settings();
        finish_run();
    end

endmodule
